FILE: rtl/ray_sphere_intersect_macros.svh
// ----------------------------------------------------------------------------
// Ray/sphere intersection assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The expression must never be true outside reset.
`define RSI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

FILE: rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// Ray/sphere intersection package
// Payload types, register indexes, widths and the per-stage step functions.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Field widths.
  localparam int DirW   = 16;
  localparam int CoordW = 32;
  localparam int DiamW  = 31;
  localparam int DistW  = 31;
  localparam int NormW  = 16;
  localparam int IdxW   = 3;

  // Internal widths.
  localparam int VW     = CoordW + 1;      // origin minus center
  localparam int ProdW  = DirW + VW;       // one term of h
  localparam int HW     = ProdW + 1;       // h, scale 2^30
  localparam int HmW    = HW - 1;          // magnitude of h
  localparam int HloW   = 25;              // low split of |h|
  localparam int HhiW   = HmW - HloW;      // high split of |h|
  localparam int RadW   = 100;             // square root radicand
  localparam int RootW  = RadW / 2;
  localparam int SqRemW = RootW + 4;
  localparam int SqSteps = RootW;
  localparam int TW     = HW + 2;          // roots of the quadratic
  localparam int TqW    = DistW;           // distance, Q15.16
  localparam int SpW    = TqW + 1 + DirW - 1;
  localparam int StepW  = SpW - 14;
  localparam int NvW    = StepW + 2;       // hit point minus center
  localparam int NvSqW  = 2 * (NvW - 1) - 2;
  localparam int MagW   = NvW - 1;
  localparam int NumW   = 63;              // rounded dividend
  localparam int QW     = 15;              // normal quotient bits
  localparam int DivRemW = RootW;
  localparam int DivSteps = QW;

  // Range limits.
  localparam longint MaxTq     = 64'h7FFF_FFFF;
  localparam longint MaxDistQ  = 64'd2000000 * 64'd65536;
  localparam longint CoordMax  = (64'sd1 <<< (CoordW - 1)) - 64'sd1;
  localparam longint CoordMin  = -CoordMax - 64'sd1;
  localparam int     NormOne   = 16384;

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    CfgOriginX  = 3'd0,
    CfgOriginY  = 3'd1,
    CfgOriginZ  = 3'd2,
    CfgCenterX  = 3'd3,
    CfgCenterY  = 3'd4,
    CfgCenterZ  = 3'd5,
    CfgDiameter = 3'd6
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
  } ray_in_t;

  // Result item.
  typedef struct packed {
    logic                     hit;
    logic        [DistW-1:0]  distance;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
  } ray_out_t;

  // One stage of the digit-by-digit square root.
  typedef struct packed {
    logic [RadW-1:0]   rad;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic [QW-1:0]      low;
    logic [QW-1:0]      q;
  } dv_t;

  // Sideband that travels with the first square root.
  typedef struct packed {
    logic                   neg;
    logic signed [HW-1:0]   h;
    logic [2:0][DirW-1:0]   dir;
  } fr_t;

  // Sideband that travels with the second square root.
  typedef struct packed {
    logic                   hit;
    logic [TqW-1:0]         tq;
    logic [2:0][CoordW-1:0] p;
    logic [2:0][NvW-1:0]    nv;
  } bk_t;

  // Sideband that travels with the divider.
  typedef struct packed {
    logic                   hit;
    logic [TqW-1:0]         tq;
    logic [2:0][CoordW-1:0] p;
    logic [2:0]             neg;
    logic                   zero;
    logic [RootW-1:0]       len;
  } ds_t;

  // Take two radicand bits and settle one root bit.
  function automatic sq_t sqrt_step(sq_t a);
    sq_t               r;
    logic [SqRemW-1:0] remx;
    logic [SqRemW-1:0] trial;
    remx  = {a.rem[SqRemW-3:0], a.rad[RadW-1 -: 2]};
    trial = SqRemW'({a.root, 2'b01});
    r.rad = {a.rad[RadW-3:0], 2'b00};
    if (remx >= trial) begin
      r.rem  = remx - trial;
      r.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = remx;
      r.root = {a.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Bring down one dividend bit and settle one quotient bit.
  function automatic dv_t div_step(dv_t a, logic [RootW-1:0] den);
    dv_t                r;
    logic [DivRemW:0]   remx;
    remx  = {a.rem, a.low[QW-1]};
    r.low = {a.low[QW-2:0], 1'b0};
    if (remx >= {1'b0, den}) begin
      r.rem = DivRemW'(remx - {1'b0, den});
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = remx[DivRemW-1:0];
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// Ray/sphere intersection
// Intersects a ray of unit direction with one sphere; gives distance, hit
// point and unit surface normal in fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Transfer when
//  -------   --------------------------------------------   ----------------
//  ray in    start, busy, ray_i                             start && !busy
//  result    done_o, result_o                               done_o
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i, data    valid && ready
//
//  A ray enters every clock cycle; busy stays low and cfg_ready_o stays high.
//  Each result appears in ray order, after passing the front and back
//  stages, two 50-stage square root pipelines and the 15-stage divider.
//  Reset zeroes the config and valid registers and so empties the pipeline.
//  The receiver cannot stall, so the pipeline advances on every clock.
//
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect import rsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ray_in_t              ray_i,
  output logic                 done_o,
  output ray_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IdxW-1:0]      cfg_index_i,
  input  logic [CoordW-1:0]    cfg_data_i
);

  // Handshakes: the pipeline never holds off either side.
  logic acc;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  // Configuration registers.
  logic signed [CoordW-1:0] origin_q [3];
  logic signed [CoordW-1:0] center_q [3];
  logic        [DiamW-1:0]  diam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        center_q[i] <= '0;
      end
      diam_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgOriginX:  origin_q[0] <= cfg_data_i;
        CfgOriginY:  origin_q[1] <= cfg_data_i;
        CfgOriginZ:  origin_q[2] <= cfg_data_i;
        CfgCenterX:  center_q[0] <= cfg_data_i;
        CfgCenterY:  center_q[1] <= cfg_data_i;
        CfgCenterZ:  center_q[2] <= cfg_data_i;
        CfgDiameter: diam_q      <= cfg_data_i[DiamW-1:0];
        default: ;
      endcase
    end
  end

  // Terms that depend on the registers alone, registered in the order v_q, vsq_q, vv_q.
  logic signed [VW-1:0]     v_q   [3];
  logic        [2*VW-1:0]   vsq_q [3];
  logic        [RadW-1:0]   vv_q;
  logic        [2*DiamW-1:0] r2_q;
  logic signed [2*VW-1:0]   vsq_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsq_d[i] = (2*VW)'(v_q[i]) * (2*VW)'(v_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i]   <= '0;
        vsq_q[i] <= '0;
      end
      vv_q <= '0;
      r2_q <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        v_q[i]   <= VW'(origin_q[i]) - VW'(center_q[i]);
        vsq_q[i] <= $unsigned(vsq_d[i]);
      end
      vv_q <= (RadW'(vsq_q[0]) + RadW'(vsq_q[1]) + RadW'(vsq_q[2])) << 28;
      r2_q <= (2*DiamW)'(diam_q) * (2*DiamW)'(diam_q);
    end
  end

  // Front stages: h = D.V, its square, and the discriminant.
  logic                     vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  logic [2:0][DirW-1:0]     dir1_q, dir2_q, dir3_q, dir4_q, dir5_q;
  logic signed [ProdW-1:0]  prod2_q [3];
  logic signed [HW-1:0]     h3_q, h4_q, h5_q;
  logic [2*HhiW-1:0]        hh4_q;
  logic [HhiW+HloW-1:0]     hl4_q;
  logic [2*HloW-1:0]        ll4_q;
  logic [RadW-1:0]          pp5_q;
  logic [HmW-1:0]           hmag;
  logic [HhiW-1:0]          hhi;
  logic [HloW-1:0]          hlo;

  assign hmag = h3_q[HW-1] ? HmW'(-h3_q) : HmW'(h3_q);
  assign hhi  = hmag[HmW-1:HloW];
  assign hlo  = hmag[HloW-1:0];

  always_ff @(posedge clk_i) begin
    dir1_q <= {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};
    dir2_q <= dir1_q;
    for (int i = 0; i < 3; i++) begin
      prod2_q[i] <= ProdW'($signed(dir1_q[i])) * ProdW'(v_q[i]);
    end
    dir3_q <= dir2_q;
    h3_q   <= HW'(prod2_q[0]) + HW'(prod2_q[1]) + HW'(prod2_q[2]);
    dir4_q <= dir3_q;
    h4_q   <= h3_q;
    hh4_q  <= (2*HhiW)'(hhi) * (2*HhiW)'(hhi);
    hl4_q  <= (HhiW+HloW)'(hhi) * (HhiW+HloW)'(hlo);
    ll4_q  <= (2*HloW)'(hlo) * (2*HloW)'(hlo);
    dir5_q <= dir4_q;
    h5_q   <= h4_q;
    pp5_q  <= (RadW'(hh4_q) << (2*HloW)) + (RadW'(hl4_q) << (HloW+1))
              + RadW'(ll4_q) + (RadW'(r2_q) << 26);
  end

  // First square root: s = isqrt(disc).
  sq_t  sq1_q  [SqSteps+1];
  fr_t  fr1_q  [SqSteps+1];
  logic vq1_q  [SqSteps+1];

  always_ff @(posedge clk_i) begin
    sq1_q[0].rad  <= pp5_q - vv_q;
    sq1_q[0].rem  <= '0;
    sq1_q[0].root <= '0;
    fr1_q[0].neg  <= pp5_q < vv_q;
    fr1_q[0].h    <= h5_q;
    fr1_q[0].dir  <= dir5_q;
    for (int k = 0; k < SqSteps; k++) begin
      sq1_q[k+1] <= sqrt_step(sq1_q[k]);
      fr1_q[k+1] <= fr1_q[k];
    end
  end

  // Back stages: pick the root, then the hit point and P - C.
  logic                     vt1_q, vt2_q, vt3_q, vt4_q, vt5_q;
  logic signed [TW-1:0]     t1_q, t2_q;
  logic                     neg_t1_q;
  logic [2:0][DirW-1:0]     dir_t1_q, dir_t2_q;
  logic                     hit_t2_q, hit_t3_q, hit_t4_q, hit_t5_q;
  logic [TqW-1:0]           tq_t2_q, tq_t3_q, tq_t4_q, tq_t5_q;
  logic signed [SpW-1:0]    sp_t3_q [3];
  logic [2:0][CoordW-1:0]   p_t4_q, p_t5_q;
  logic [2:0][NvW-1:0]      nv_t4_q, nv_t5_q;
  logic [NvSqW-1:0]         nsq_t5_q [3];

  logic signed [TW-1:0]     hx, sx, t_sel, tq_full;
  logic                     hit_d;
  logic signed [StepW-1:0]  step [3];
  logic signed [NvW-1:0]    psum [3];
  logic [2:0][CoordW-1:0]   p_d;
  logic [2:0][NvW-1:0]      nv_d;
  logic signed [2*NvW-1:0]  nsq_d [3];

  assign hx      = TW'(fr1_q[SqSteps].h);
  assign sx      = $signed(TW'(sq1_q[SqSteps].root));
  assign t_sel   = (t1_q > 0) ? t1_q : t2_q;
  assign tq_full = t_sel >>> 14;
  assign hit_d   = !neg_t1_q && !t2_q[TW-1] && (tq_full > 0)
                   && (tq_full <= TW'(MaxTq)) && (tq_full < TW'(MaxDistQ));

  // Hit point saturates; P - C keeps full width.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i] = StepW'(sp_t3_q[i] >>> 14);
      psum[i] = NvW'(origin_q[i]) + NvW'(step[i]);
      if (psum[i] > NvW'(CoordMax)) begin
        p_d[i] = CoordW'(CoordMax);
      end else if (psum[i] < NvW'(CoordMin)) begin
        p_d[i] = CoordW'(CoordMin);
      end else begin
        p_d[i] = psum[i][CoordW-1:0];
      end
      nv_d[i]  = NvW'(v_q[i]) + NvW'(step[i]);
      nsq_d[i] = (2*NvW)'($signed(nv_t4_q[i])) * (2*NvW)'($signed(nv_t4_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q     <= -hx - sx;
    t2_q     <= -hx + sx;
    neg_t1_q <= fr1_q[SqSteps].neg;
    dir_t1_q <= fr1_q[SqSteps].dir;
    hit_t2_q <= hit_d;
    tq_t2_q  <= tq_full[TqW-1:0];
    dir_t2_q <= dir_t1_q;
    hit_t3_q <= hit_t2_q;
    tq_t3_q  <= tq_t2_q;
    for (int i = 0; i < 3; i++) begin
      sp_t3_q[i]  <= SpW'($signed({1'b0, tq_t2_q})) * SpW'($signed(dir_t2_q[i]));
      nsq_t5_q[i] <= nsq_d[i][NvSqW-1:0];
    end
    hit_t4_q <= hit_t3_q;
    tq_t4_q  <= tq_t3_q;
    p_t4_q   <= p_d;
    nv_t4_q  <= nv_d;
    hit_t5_q <= hit_t4_q;
    tq_t5_q  <= tq_t4_q;
    p_t5_q   <= p_t4_q;
    nv_t5_q  <= nv_t4_q;
  end

  // Second square root: length of P - C.
  sq_t  sq2_q [SqSteps+1];
  bk_t  bk2_q [SqSteps+1];
  logic vq2_q [SqSteps+1];

  always_ff @(posedge clk_i) begin
    sq2_q[0].rad  <= (RadW'(nsq_t5_q[0]) + RadW'(nsq_t5_q[1]) + RadW'(nsq_t5_q[2])) << 28;
    sq2_q[0].rem  <= '0;
    sq2_q[0].root <= '0;
    bk2_q[0].hit  <= hit_t5_q;
    bk2_q[0].tq   <= tq_t5_q;
    bk2_q[0].p    <= p_t5_q;
    bk2_q[0].nv   <= nv_t5_q;
    for (int k = 0; k < SqSteps; k++) begin
      sq2_q[k+1] <= sqrt_step(sq2_q[k]);
      bk2_q[k+1] <= bk2_q[k];
    end
  end

  // Divider: rounded |P - C| * 2^28 / length, one quotient bit a stage.
  dv_t  dv_q [DivSteps+1][3];
  ds_t  ds_q [DivSteps+1];
  logic vd_q [DivSteps+1];

  logic [RootW-1:0] len;
  logic [MagW-1:0]  nmag [3];
  logic [NumW-1:0]  num  [3];

  assign len = sq2_q[SqSteps].root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = bk2_q[SqSteps].nv[i][NvW-1] ? MagW'(-$signed(bk2_q[SqSteps].nv[i]))
                                            : MagW'(bk2_q[SqSteps].nv[i]);
      num[i]  = NumW'({nmag[i], 28'd0}) + NumW'(len >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_q[0][i].rem <= DivRemW'(num[i][NumW-1:QW]);
      dv_q[0][i].low <= num[i][QW-1:0];
      dv_q[0][i].q   <= '0;
      ds_q[0].neg[i] <= bk2_q[SqSteps].nv[i][NvW-1];
    end
    ds_q[0].hit  <= bk2_q[SqSteps].hit;
    ds_q[0].tq   <= bk2_q[SqSteps].tq;
    ds_q[0].p    <= bk2_q[SqSteps].p;
    ds_q[0].zero <= (len == '0);
    ds_q[0].len  <= len;
    for (int k = 0; k < DivSteps; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[k+1][i] <= div_step(dv_q[k][i], ds_q[k].len);
      end
      ds_q[k+1] <= ds_q[k];
    end
  end

  // Result assembly: a miss gives all zero fields.
  ray_out_t result_d;
  ray_out_t result_q;
  logic     done_q;
  logic [QW-1:0]          u    [3];
  logic signed [NormW-1:0] nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = (dv_q[DivSteps][i].q > QW'(NormOne)) ? QW'(NormOne) : dv_q[DivSteps][i].q;
      if (ds_q[DivSteps].zero) begin
        nrm[i] = '0;
      end else if (ds_q[DivSteps].neg[i]) begin
        nrm[i] = -$signed(NormW'(u[i]));
      end else begin
        nrm[i] = $signed(NormW'(u[i]));
      end
    end
    result_d = '0;
    if (ds_q[DivSteps].hit) begin
      result_d.hit      = 1'b1;
      result_d.distance = ds_q[DivSteps].tq;
      result_d.hit_x    = ds_q[DivSteps].p[0];
      result_d.hit_y    = ds_q[DivSteps].p[1];
      result_d.hit_z    = ds_q[DivSteps].p[2];
      result_d.normal_x = nrm[0];
      result_d.normal_y = nrm[1];
      result_d.normal_z = nrm[2];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vt1_q  <= 1'b0;
      vt2_q  <= 1'b0;
      vt3_q  <= 1'b0;
      vt4_q  <= 1'b0;
      vt5_q  <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k <= SqSteps; k++) begin
        vq1_q[k] <= 1'b0;
        vq2_q[k] <= 1'b0;
      end
      for (int k = 0; k <= DivSteps; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else begin
      vld1_q   <= acc;
      vld2_q   <= vld1_q;
      vld3_q   <= vld2_q;
      vld4_q   <= vld3_q;
      vld5_q   <= vld4_q;
      vq1_q[0] <= vld5_q;
      for (int k = 0; k < SqSteps; k++) begin
        vq1_q[k+1] <= vq1_q[k];
        vq2_q[k+1] <= vq2_q[k];
      end
      vt1_q    <= vq1_q[SqSteps];
      vt2_q    <= vt1_q;
      vt3_q    <= vt2_q;
      vt4_q    <= vt3_q;
      vt5_q    <= vt4_q;
      vq2_q[0] <= vt5_q;
      vd_q[0]  <= vq2_q[SqSteps];
      for (int k = 0; k < DivSteps; k++) begin
        vd_q[k+1] <= vd_q[k];
      end
      done_q   <= vd_q[DivSteps];
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Checks on the assembled results.
  `RSI_ASSERT(a_miss_zero, done_o && !result_o.hit |-> result_o == '0, "miss with nonzero fields")
  `RSI_NEVER(a_hit_dist, done_o && result_o.hit && result_o.distance == '0, "hit at zero distance")
  `RSI_ASSERT(a_norm_x, done_o && result_o.hit |-> result_o.normal_x <= 16'sd16384
              && result_o.normal_x >= -16'sd16384, "normal x out of range")
  `RSI_ASSERT(a_hit_flow, done_o && result_o.hit |-> $past(vd_q[DivSteps])
              && $past(ds_q[DivSteps].hit), "hit without a tracked item")

endmodule

FILE: tb/ray_sphere_intersect_test.sv
// ----------------------------------------------------------------------------
// Ray/sphere intersection testbench
// Drives ray directions and register writes into the block, predicts every
// result in fixed point and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_sphere_intersect_test;
  import rsi_pkg::*;

  localparam int     WatchLimit = 4000;
  localparam int     SettleCycles = 200;
  localparam longint DistLimitQ = 64'sd131072000000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  ray_in_t         ray_i;
  logic            done_o;
  ray_out_t        result_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [IdxW-1:0] cfg_index_i;
  logic [CoordW-1:0] cfg_data_i;

  // Shadow of the block's registers and the queue of predicted results.
  logic [31:0] reg_copy [7];
  ray_out_t    hit_queue [$];
  int          error_count;
  int          idle_pct;
  int          quiet_cycles;

  ray_sphere_intersect uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .ray_i       (ray_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Square of a signed value as a 128-bit magnitude.
  function automatic logic [127:0] square_wide(longint x);
    logic [63:0] m;
    m = (x < 0) ? 64'(-x) : 64'(x);
    return {64'b0, m} * {64'b0, m};
  endfunction

  // Floor square root of a 128-bit value, one bit at a time.
  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [63:0] acc;
    logic [63:0] c;
    acc = '0;
    for (int b = 63; b >= 0; b--) begin
      c = acc | (64'd1 << b);
      if (x >= {64'b0, c} * {64'b0, c}) acc = c;
    end
    return acc;
  endfunction

  // Expected intersection result for one direction under the current registers.
  function automatic ray_out_t predict_hit(ray_in_t r);
    longint       dv [3];
    longint       ov [3];
    longint       vc [3];
    longint       nv [3];
    longint       pv [3];
    longint       h, s, t1, t2, t, tq, stp;
    logic [127:0] vsq, pp, disc, nn, dm;
    logic [63:0]  len, num, u, mg;
    logic [15:0]  nq [3];
    ray_out_t     res;
    res = '0;
    h = 0;
    vsq = '0;
    nn = '0;
    dv[0] = r.dir_x;
    dv[1] = r.dir_y;
    dv[2] = r.dir_z;
    for (int i = 0; i < 3; i++) begin
      ov[i] = $signed(reg_copy[i]);
      vc[i] = ov[i] - longint'($signed(reg_copy[3 + i]));
      h += dv[i] * vc[i];
      vsq += square_wide(vc[i]);
    end
    vsq = vsq << 28;
    dm = {97'b0, reg_copy[CfgDiameter][30:0]};
    pp = square_wide(h) + ((dm * dm) << 26);
    // Negative discriminant is a miss.
    if (pp < vsq) return res;
    disc = pp - vsq;
    s = longint'(root_floor(disc));
    t1 = -h - s;
    t2 = -h + s;
    // Sphere entirely behind the origin.
    if (t2 < 0) return res;
    t = (t1 > 0) ? t1 : t2;
    tq = t >>> 14;
    // Zero or out-of-range distance counts as a miss.
    if (tq <= 0 || tq >= DistLimitQ || tq > 64'sh7FFF_FFFF) return res;
    for (int i = 0; i < 3; i++) begin
      stp = (tq * dv[i]) >>> 14;
      pv[i] = ov[i] + stp;
      if (pv[i] > CoordMax) pv[i] = CoordMax;
      if (pv[i] < CoordMin) pv[i] = CoordMin;
      nv[i] = vc[i] + stp;
      nn += square_wide(nv[i]);
    end
    len = root_floor(nn << 28);
    for (int i = 0; i < 3; i++) begin
      nq[i] = '0;
      if (len != 0) begin
        mg = (nv[i] < 0) ? 64'(-nv[i]) : 64'(nv[i]);
        num = mg << 28;
        u = (num + len / 2) / len;
        if (u > 64'd16384) u = 64'd16384;
        nq[i] = (nv[i] < 0) ? 16'(-u) : 16'(u);
      end
    end
    res.hit      = 1'b1;
    res.distance = tq[30:0];
    res.hit_x    = pv[0][31:0];
    res.hit_y    = pv[1][31:0];
    res.hit_z    = pv[2][31:0];
    res.normal_x = nq[0];
    res.normal_y = nq[1];
    res.normal_z = nq[2];
    return res;
  endfunction

  // Monitor: checks results, predicts on each ray transfer, tracks registers.
  always @(posedge clk_i) begin
    ray_out_t ex;
    if (rst_ni) begin
      if (done_o) begin
        if (hit_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %h", $time, result_o);
        end else begin
          ex = hit_queue.pop_front();
          if (ex !== result_o) begin
            error_count++;
            if (ex.hit !== result_o.hit)
              $display("%0t: hit exp %h got %h", $time, ex.hit, result_o.hit);
            if (ex.distance !== result_o.distance)
              $display("%0t: distance exp %h got %h", $time, ex.distance,
                       result_o.distance);
            if (ex.hit_x !== result_o.hit_x)
              $display("%0t: hit_x exp %h got %h", $time, ex.hit_x, result_o.hit_x);
            if (ex.hit_y !== result_o.hit_y)
              $display("%0t: hit_y exp %h got %h", $time, ex.hit_y, result_o.hit_y);
            if (ex.hit_z !== result_o.hit_z)
              $display("%0t: hit_z exp %h got %h", $time, ex.hit_z, result_o.hit_z);
            if (ex.normal_x !== result_o.normal_x)
              $display("%0t: normal_x exp %h got %h", $time, ex.normal_x,
                       result_o.normal_x);
            if (ex.normal_y !== result_o.normal_y)
              $display("%0t: normal_y exp %h got %h", $time, ex.normal_y,
                       result_o.normal_y);
            if (ex.normal_z !== result_o.normal_z)
              $display("%0t: normal_z exp %h got %h", $time, ex.normal_z,
                       result_o.normal_z);
          end
        end
      end
      if (start && !busy) hit_queue.push_back(predict_hit(ray_i));
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < 3'd7)
        reg_copy[cfg_index_i] = (cfg_index_i == CfgDiameter) ?
                                {1'b0, cfg_data_i[30:0]} : cfg_data_i;
      // Watchdog on cycles with no transfer at all.
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Send one ray; returns at the falling edge after its transfer.
  task automatic send_ray(ray_in_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    ray_i <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Wait with the ray channel quiet until every predicted result has arrived.
  task automatic wait_idle();
    start <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk_i);
  endtask

  // One register write transfer; valid stays high until the caller drops it.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_scene(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] dia);
    wait_idle();
    write_reg(CfgOriginX, ox);
    write_reg(CfgOriginY, oy);
    write_reg(CfgOriginZ, oz);
    write_reg(CfgCenterX, cx);
    write_reg(CfgCenterY, cy);
    write_reg(CfgCenterZ, cz);
    write_reg(CfgDiameter, dia);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic ray_in_t dir_of(int x, int y, int z);
    ray_in_t r;
    r.dir_x = 16'(x);
    r.dir_y = 16'(y);
    r.dir_z = 16'(z);
    return r;
  endfunction

  // Random direction of unit length in Q1.14.
  function automatic ray_in_t unit_dir();
    real x, y, z, n;
    do begin
      x = real'($urandom_range(2000)) - 1000.0;
      y = real'($urandom_range(2000)) - 1000.0;
      z = real'($urandom_range(2000)) - 1000.0;
      n = $sqrt(x * x + y * y + z * z);
    end while (n < 1.0);
    return dir_of($rtoi(x / n * 16384.0), $rtoi(y / n * 16384.0),
                  $rtoi(z / n * 16384.0));
  endfunction

  // Small signed value in Q16.16 with magnitude below 2^bits.
  function automatic logic [31:0] near_coord(int bits);
    return 32'($signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // With reset registers the sphere is a point at the origin: always a miss.
  task automatic test_reset_state();
    send_ray(dir_of(16384, 0, 0));
    send_ray(dir_of(0, -16384, 0));
  endtask

  task automatic test_special_cases();
    // Degenerate normal: zero-size sphere lying exactly on the ray.
    set_scene(0, 0, 0, 32'd10 << 16, 0, 0, 0);
    send_ray(dir_of(16384, 0, 0));
    // Ordinary hit, then misses by negative discriminant and one behind.
    set_scene(0, 0, 0, 32'd10 << 16, 0, 0, 32'd4 << 16);
    send_ray(dir_of(16384, 0, 0));
    send_ray(dir_of(0, 16384, 0));
    send_ray(dir_of(-16384, 0, 0));
    send_ray(dir_of(11585, 11585, 0));
    // Zero distance: tiny sphere around the origin.
    set_scene(0, 0, 0, 0, 0, 0, 1);
    send_ray(dir_of(16384, 0, 0));
    send_ray(dir_of(0, 0, -16384));
    // Hit point overflow with origin at the top of the range.
    set_scene(32'h7FFF_0000, 32'h8000_0000, 0, 32'h7FFF_0000, 32'h8000_0000, 0,
              32'hFFFF_FFFF);
    send_ray(dir_of(16384, 0, 0));
    send_ray(dir_of(0, -16384, 0));
    send_ray(dir_of(32767, 32767, 32767));
    send_ray(dir_of(-32768, -32768, -32768));
    // Non-unit directions from inside a moderate sphere.
    set_scene(0, 0, 0, 32'd1 << 16, 0, 0, 32'd20 << 16);
    send_ray(dir_of(16384, 16384, 16384));
    send_ray(dir_of(1, 0, 0));
    send_ray(dir_of(0, 0, 0));
    send_ray(dir_of(-16384, 16384, -16384));
    send_ray(dir_of(32767, -32768, 12345));
    // Index beyond the register list is ignored.
    wait_idle();
    write_reg(3'd7, 32'hDEAD_BEEF);
    cfg_valid_i <= 1'b0;
    send_ray(dir_of(16384, 0, 0));
  endtask

  // Random scene of a given kind, then a batch of rays under it.
  task automatic test_random_scene(int kind, int count);
    logic [31:0] dia;
    dia = {1'($urandom_range(1)), 31'($urandom_range(32'h007F_FFFF))};
    case (kind)
      0: begin
        set_scene(near_coord(20), near_coord(20), near_coord(20),
                  near_coord(22), near_coord(22), near_coord(22), dia);
      end
      1: begin
        set_scene($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      end
      default: begin
        set_scene({$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom)},
                  $urandom, near_coord(24),
                  {$urandom_range(1) ? 16'h8000 : 16'h7FFF, 16'($urandom)},
                  near_coord(28), near_coord(24),
                  $urandom_range(1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF);
      end
    endcase
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0)
        send_ray(dir_of($urandom, $urandom, $urandom));
      else
        send_ray(unit_dir());
    end
  endtask

  task automatic test_random_traffic();
    int pcts [3];
    pcts = '{0, 85, 30};
    for (int p = 0; p < 3; p++) begin
      idle_pct = pcts[p];
      for (int k = 0; k < 3; k++) test_random_scene(k, 190);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    ray_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    error_count = 0;
    idle_pct    = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 7; i++) reg_copy[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_special_cases();
    test_random_traffic();

    wait_idle();
    repeat (SettleCycles) @(negedge clk_i);
    if (hit_queue.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rsi_pkg.sv
rtl/ray_sphere_intersect.sv
tb/ray_sphere_intersect_test.sv
